@@ sv/gbte_pkg.sv @@
// ----------------------------------------------------------------------------
// gbte_pkg
// shared constants and controller/datapath interface types for the gap buffer
// ----------------------------------------------------------------------------
package gbte_pkg;

   localparam int CAPACITY = 4096;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int POS_W    = ADDR_W + 1;
   localparam int MOVE_W   = 14;

   localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_MOVE   = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_EDGE = 2'd2;

   typedef struct packed {
      logic accept;
      logic move_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic move_go;
      logic count_zero;
   } stat_type;

endpackage

@@ sv/gbte_ctrl.sv @@
// ----------------------------------------------------------------------------
// gbte_ctrl
// sequencer: accept, byte copy across the gap, neighbor read, result hand-off
// ----------------------------------------------------------------------------
module gbte_ctrl import gbte_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_MOVE = 4'b0010,
      S_READ = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;
   logic      accept, load;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign load       = (state_ff == S_DONE) && (!rsp_tvalid_ff || rsp_tready);
   assign rsp_tvalid = rsp_tvalid_ff;

   assign cmd.accept    = accept;
   assign cmd.move_step = (state_ff == S_MOVE) && !stat.count_zero;
   assign cmd.load_out  = load;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = stat.move_go ? S_MOVE : S_READ;
            end
         end
         S_MOVE: begin
            if (stat.count_zero) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      priority if (load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

endmodule

@@ sv/gbte_dpath.sv @@
// ----------------------------------------------------------------------------
// gbte_dpath
// gap pointers, byte store, copy pipeline and result register
// ----------------------------------------------------------------------------
module gbte_dpath import gbte_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [1:0]               req_operation,
   input  logic [7:0]               req_char_value,
   input  logic signed [MOVE_W-1:0] req_move_by,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   output logic [1:0]               rsp_status,
   output logic [POS_W-1:0]         rsp_cursor,
   output logic [POS_W-1:0]         rsp_text_length,
   output logic [7:0]               rsp_byte_before,
   output logic [7:0]               rsp_byte_after
);

   localparam int SW = POS_W + 2;

   logic [7:0]        mem [CAPACITY];

   logic [POS_W-1:0]  gap_start_ff, gap_stop_ff;
   logic [POS_W-1:0]  count_ff;
   logic              left_ff;
   logic [1:0]        status_ff;
   logic              wr_pend_ff;
   logic [ADDR_W-1:0] wr_addr_ff;
   logic [7:0]        rd0_ff, rd1_ff;

   logic [1:0]        status_out_ff;
   logic [POS_W-1:0]  cursor_out_ff, length_out_ff;
   logic [7:0]        before_out_ff, after_out_ff;

   logic signed [SW-1:0] want_s, lo_s, hi_s, mv_n, mv_abs;
   logic                 mv_edge;
   logic                 ins_ok;
   logic                 we;
   logic [ADDR_W-1:0]    waddr, raddr0, raddr1;
   logic [7:0]           wdata;
   logic [POS_W-1:0]     start_dec, stop_dec;

   assign want_s = SW'(req_move_by);
   assign lo_s   = -signed'(SW'(gap_start_ff));
   assign hi_s   = signed'(SW'(CAP_POS - gap_stop_ff));

   always_comb begin
      mv_n = want_s;
      if (want_s < lo_s) begin
         mv_n = lo_s;
      end
      if (want_s > hi_s) begin
         mv_n = hi_s;
      end
   end

   assign mv_edge = (mv_n != want_s);
   assign mv_abs  = (mv_n < 0) ? -mv_n : mv_n;
   assign ins_ok  = (gap_start_ff < gap_stop_ff);

   assign stat.move_go    = (req_operation == OP_MOVE) && (mv_n != '0);
   assign stat.count_zero = (count_ff == '0);

   assign start_dec = gap_start_ff - POS_W'(1);
   assign stop_dec  = gap_stop_ff - POS_W'(1);

   // memory ports
   assign we     = wr_pend_ff || (cmd.accept && (req_operation == OP_INSERT) && ins_ok);
   assign waddr  = wr_pend_ff ? wr_addr_ff : gap_start_ff[ADDR_W-1:0];
   assign wdata  = wr_pend_ff ? rd0_ff : req_char_value;
   assign raddr0 = (cmd.move_step && !left_ff) ? gap_stop_ff[ADDR_W-1:0]
                                               : start_dec[ADDR_W-1:0];
   assign raddr1 = gap_stop_ff[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd0_ff <= mem[raddr0];
      rd1_ff <= mem[raddr1];
   end

   // gap pointers and copy control
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_start_ff <= '0;
         gap_stop_ff  <= CAP_POS;
         count_ff     <= '0;
         left_ff      <= 1'b0;
         status_ff    <= ST_OK;
         wr_pend_ff   <= 1'b0;
      end else begin
         wr_pend_ff <= cmd.move_step;
         if (cmd.accept) begin
            unique case (req_operation)
               OP_INSERT: begin
                  status_ff <= ins_ok ? ST_OK : ST_FULL;
                  if (ins_ok) begin
                     gap_start_ff <= gap_start_ff + POS_W'(1);
                  end
               end
               OP_DELETE: begin
                  status_ff <= (gap_start_ff != '0) ? ST_OK : ST_EDGE;
                  if (gap_start_ff != '0) begin
                     gap_start_ff <= start_dec;
                  end
               end
               OP_MOVE: begin
                  status_ff <= mv_edge ? ST_EDGE : ST_OK;
                  count_ff  <= mv_abs[POS_W-1:0];
                  left_ff   <= (mv_n < 0);
               end
               default: status_ff <= ST_OK;
            endcase
         end else if (cmd.move_step) begin
            count_ff <= count_ff - POS_W'(1);
            if (left_ff) begin
               gap_start_ff <= start_dec;
               gap_stop_ff  <= stop_dec;
            end else begin
               gap_start_ff <= gap_start_ff + POS_W'(1);
               gap_stop_ff  <= gap_stop_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.move_step) begin
         wr_addr_ff <= left_ff ? stop_dec[ADDR_W-1:0] : gap_start_ff[ADDR_W-1:0];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         status_out_ff <= status_ff;
         cursor_out_ff <= gap_start_ff;
         length_out_ff <= gap_start_ff + (CAP_POS - gap_stop_ff);
         before_out_ff <= (gap_start_ff != '0) ? rd0_ff : 8'd0;
         after_out_ff  <= (gap_stop_ff != CAP_POS) ? rd1_ff : 8'd0;
      end
   end

   assign rsp_status      = status_out_ff;
   assign rsp_cursor      = cursor_out_ff;
   assign rsp_text_length = length_out_ff;
   assign rsp_byte_before = before_out_ff;
   assign rsp_byte_after  = after_out_ff;

endmodule

@@ sv/gap_buffer_text_editor.sv @@
// ----------------------------------------------------------------------------
// gap_buffer_text_editor
// fixed-capacity gap buffer: insert, delete before cursor, move cursor
//
//   channel | dir | words
//   req_    | in  | one edit operation
//   rsp_    | out | one result per operation
//
// insert, delete, zero move: accept, then the read state, then the done state loads the result register
// move by n (after clamp): |n| bytes copied in the move state, one byte copied per cycle
// through the single write port of the byte store
// the store is not cleared by reset; the gap pointers, copy control and status reset
// the next word is taken once the result sits in the output register
// ----------------------------------------------------------------------------
module gap_buffer_text_editor import gbte_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // char_value, move_by, zero pad
   input  logic [1:0]  req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // cursor, text_length, byte_before, byte_after, zero pad
   output logic [1:0]  rsp_tuser    // status
);

   cmd_type          cmd;
   stat_type         stat;
   logic [1:0]       status;
   logic [POS_W-1:0] cursor, text_length;
   logic [7:0]       byte_before, byte_after;

   gbte_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   gbte_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_operation   (req_tuser),
      .req_char_value  (req_tdata[7:0]),
      .req_move_by     (signed'(req_tdata[21:8])),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_status      (status),
      .rsp_cursor      (cursor),
      .rsp_text_length (text_length),
      .rsp_byte_before (byte_before),
      .rsp_byte_after  (byte_after)
   );

   assign rsp_tuser = status;
   assign rsp_tdata = {6'd0, byte_after, byte_before, text_length, cursor};

endmodule

@@ dv/gap_buffer_text_editor_tb.sv @@
// ----------------------------------------------------------------------------
// gap_buffer_text_editor_tb
// self-checking bench for the fixed-capacity gap buffer
//
// edit words go in on req_ and result words come back on rsp_, both with
// random idle gaps. A behavioral gap buffer in the bench predicts the
// results: status, cursor, text length and the bytes on both sides of the
// cursor. A short table covers the corner cases, some rows with their own
// expected results. Random edits on a short text follow, and then long
// cursor moves across the whole text with edits at both ends.
// ----------------------------------------------------------------------------
module gap_buffer_text_editor_tb;
   import gbte_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED  = 2'd3;
   localparam int         IDLE_LIMIT = 20000;
   localparam int         HOLD_LEN   = 300;
   localparam int         RAND_EDITS = 820;

   typedef struct packed {
      logic [1:0]  status;
      logic [12:0] cursor;
      logic [12:0] text_len;
      logic [7:0]  byte_before;
      logic [7:0]  byte_after;
   } edit_result_type;

   typedef struct {
      logic [1:0]         op;
      logic [7:0]         ch;
      logic signed [13:0] mv;
      bit                 known;
      edit_result_type    res;
   } edit_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // char_value, move_by, zero pad
   logic [1:0]  req_tuser = '0;   // operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // cursor, text_length, byte_before, byte_after, zero pad
   logic [1:0]  rsp_tuser;        // status

   // typed expectation travels with the word it belongs to
   bit              req_known = 1'b0;
   edit_result_type req_typed = '0;

   logic [7:0]      text_model [CAPACITY];
   int              gap_lo = 0;
   int              gap_hi = CAPACITY;
   edit_result_type expected_results [$];
   edit_row_type    corner_rows [$];

   int fails = 0;
   int n_edits = 0;
   int n_full = 0;
   int n_edge = 0;
   int n_checked = 0;
   int longest_move = 0;
   int max_len = 0;
   int idle_cycles = 0;
   bit hold_rsp = 1'b0;

   gap_buffer_text_editor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   function automatic edit_result_type apply_edit(input logic [1:0] op, input logic [7:0] ch,
                                                  input logic signed [13:0] mv);
      edit_result_type r;
      int want;
      int n;
      r.status = ST_OK;
      if (op == OP_INSERT) begin
         if (gap_lo >= gap_hi) begin
            r.status = ST_FULL;
         end else begin
            text_model[gap_lo] = ch;
            gap_lo++;
         end
      end else if (op == OP_DELETE) begin
         if (gap_lo > 0) gap_lo--;
         else r.status = ST_EDGE;
      end else if (op == OP_MOVE) begin
         want = int'(mv);
         n = want;
         if (n < -gap_lo) n = -gap_lo;
         if (n > CAPACITY - gap_hi) n = CAPACITY - gap_hi;
         if (n != want) r.status = ST_EDGE;
         if (n > 0) begin
            for (int i = 0; i < n; i++) text_model[gap_lo + i] = text_model[gap_hi + i];
         end else begin
            for (int i = 0; i < -n; i++)
               text_model[gap_hi - i - 1] = text_model[gap_lo - i - 1];
         end
         gap_lo += n;
         gap_hi += n;
         if (n > longest_move) longest_move = n;
         if (-n > longest_move) longest_move = -n;
      end
      r.cursor      = 13'(gap_lo);
      r.text_len    = 13'(gap_lo + CAPACITY - gap_hi);
      r.byte_before = (gap_lo > 0) ? text_model[gap_lo - 1] : 8'h00;
      r.byte_after  = (gap_hi < CAPACITY) ? text_model[gap_hi] : 8'h00;
      return r;
   endfunction

   // scoreboard: predict on input accept, compare on output accept
   always @(posedge clock) begin
      edit_result_type got;
      edit_result_type want;
      edit_result_type pred;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tuser, rsp_tdata[12:0], rsp_tdata[25:13], rsp_tdata[33:26],
                    rsp_tdata[41:34]};
            if (expected_results.size() == 0) begin
               $error("result word with nothing expected");
               fails++;
            end else begin
               want = expected_results.pop_front();
               n_checked++;
               if (got.status != want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  fails++;
               end
               if (got.cursor != want.cursor) begin
                  $error("cursor: expected %0d, got %0d", want.cursor, got.cursor);
                  fails++;
               end
               if (got.text_len != want.text_len) begin
                  $error("text_length: expected %0d, got %0d", want.text_len, got.text_len);
                  fails++;
               end
               if (got.byte_before != want.byte_before) begin
                  $error("byte_before: expected %h, got %h", want.byte_before,
                         got.byte_before);
                  fails++;
               end
               if (got.byte_after != want.byte_after) begin
                  $error("byte_after: expected %h, got %h", want.byte_after, got.byte_after);
                  fails++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            pred = apply_edit(req_tuser, req_tdata[7:0], req_tdata[21:8]);
            expected_results.push_back(req_known ? req_typed : pred);
            n_edits++;
            if (pred.status == ST_FULL) n_full++;
            if (pred.status == ST_EDGE) n_edge++;
            if (int'(pred.text_len) > max_len) max_len = int'(pred.text_len);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   // result side back-pressure
   initial begin
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_LEN) @(posedge clock);
         end else if ($urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat (pick_gap() + 1) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   task automatic send_edit(input logic [1:0] op, input logic [7:0] ch,
                            input logic signed [13:0] mv, input bit known = 1'b0,
                            input edit_result_type res = '0);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, mv, ch};
      req_known  <= known;
      req_typed  <= res;
      do @(posedge clock); while (!req_tready);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic add_row(input logic [1:0] op, input logic [7:0] ch,
                          input logic signed [13:0] mv, input bit known = 1'b0,
                          input logic [1:0] st = ST_OK, input int cur = 0, input int len = 0,
                          input logic [7:0] bb = 8'h00, input logic [7:0] ba = 8'h00);
      edit_row_type row;
      row.op  = op;
      row.ch  = ch;
      row.mv  = mv;
      row.known = known;
      row.res = '{st, 13'(cur), 13'(len), bb, ba};
      corner_rows.push_back(row);
   endtask

   function automatic logic signed [13:0] pick_move();
      if ($urandom_range(0, 9) == 0) return 14'($urandom_range(0, 16383));
      return $urandom_range(0, 1) ? 14'($urandom_range(0, 40)) : -14'($urandom_range(0, 40));
   endfunction

   initial begin
      logic [1:0] op;
      int r;

      add_row(OP_DELETE, 8'h00, 14'sd0,    1'b1, ST_EDGE, 0, 0);
      add_row(OP_MOVE,   8'h00, 14'sd5,    1'b1, ST_EDGE, 0, 0);
      add_row(OP_MOVE,   8'h00, 14'sh2000, 1'b1, ST_EDGE, 0, 0);
      add_row(OP_MOVE,   8'hff, 14'sd8191, 1'b1, ST_EDGE, 0, 0);
      add_row(OP_MOVE,   8'h00, 14'sd0,    1'b1, ST_OK,   0, 0);
      add_row(OP_UNUSED, 8'hff, -14'sd1,   1'b1, ST_OK,   0, 0);
      add_row(OP_INSERT, 8'hff, 14'sh3fff, 1'b1, ST_OK,   1, 1, 8'hff);
      add_row(OP_INSERT, 8'h00, 14'sd0,    1'b1, ST_OK,   2, 2, 8'h00);
      add_row(OP_INSERT, 8'h5a, 14'sd7,    1'b1, ST_OK,   3, 3, 8'h5a);
      add_row(OP_INSERT, 8'ha5, 14'sd0);
      add_row(OP_MOVE,   8'h12, -14'sd1);
      add_row(OP_MOVE,   8'h00, -14'sd2);
      add_row(OP_MOVE,   8'h00, -14'sd4096);
      add_row(OP_DELETE, 8'h77, 14'sd3);
      add_row(OP_MOVE,   8'h00, 14'sd4096);
      add_row(OP_MOVE,   8'h00, -14'sd3);
      add_row(OP_INSERT, 8'h3c, 14'sd0);
      add_row(OP_DELETE, 8'h00, 14'sd0);
      add_row(OP_MOVE,   8'h00, 14'sd2);
      add_row(OP_MOVE,   8'h00, 14'sd1);
      add_row(OP_UNUSED, 8'h00, 14'sd4);
      add_row(OP_DELETE, 8'h00, 14'sd0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (corner_rows[i])
         send_edit(corner_rows[i].op, corner_rows[i].ch, corner_rows[i].mv,
                   corner_rows[i].known, corner_rows[i].res);

      for (int i = 0; i < RAND_EDITS; i++) begin
         if (i == 300) hold_rsp = 1'b1;
         if (i == 450) drain_results();
         r = $urandom_range(0, 99);
         if (r < 42) op = OP_INSERT;
         else if (r < 65) op = OP_DELETE;
         else if (r < 95) op = OP_MOVE;
         else op = OP_UNUSED;
         send_edit(op, 8'($urandom_range(0, 255)), pick_move());
      end

      // long cursor moves across the whole text, edits at both ends
      drain_results();
      send_edit(OP_MOVE, 8'h00, -14'sd4096);
      send_edit(OP_INSERT, 8'h11, 14'sd0);
      send_edit(OP_DELETE, 8'h00, 14'sd0);
      send_edit(OP_MOVE, 8'h00, 14'sd2000);
      send_edit(OP_INSERT, 8'h22, 14'sd0);
      send_edit(OP_DELETE, 8'h00, 14'sd0);
      send_edit(OP_INSERT, 8'h33, 14'sd0);
      send_edit(OP_MOVE, 8'h00, 14'sd8191);
      send_edit(OP_INSERT, 8'h44, 14'sd0);
      for (int i = 0; i < 40; i++) begin
         op = ($urandom_range(0, 2) == 0) ? OP_MOVE : OP_DELETE;
         send_edit(op, 8'($urandom_range(0, 255)), pick_move());
      end

      drain_results();
      repeat (20) @(posedge clock);
      $display("edits applied %0d, results checked %0d, full %0d, boundary %0d",
               n_edits, n_checked, n_full, n_edge);
      $display("longest cursor move %0d bytes, longest text %0d of %0d bytes",
               longest_move, max_len, CAPACITY);
      if (fails == 0 && expected_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
